/* rtl/core/berode_pkg.sv */
// Package for the 3x3 binary erosion core.
// Holds field widths, register indexes, reset values and stage types.
// Used by binary_erode_3x3_core; depends on nothing.
package berode_pkg;

	localparam int PIX_W = 8;
	localparam int ROW_W = 12;
	localparam int FW_W  = 11;
	localparam int CFG_W = 12;
	localparam int CLAMP_W = 13;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [ROW_W-1:0] HEIGHT_MIN       = 12'd3;
	localparam logic [CLAMP_W-1:0] WIDTH_MIN      = 13'd3;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	// per-request flags carried into the compute stage
	typedef struct packed {
		logic has_result;
		logic last;
	} stage_flags_t;

endpackage

/* rtl/core/binary_erode_3x3_core.sv */
// Top level of the streaming 3x3 binary erosion core.
// Depends on berode_pkg for widths, register indexes and stage types.
//   Pixels enter in raster order on the in_valid/in_ready channel, one request
//   per pixel; frame_start marks row 0, col 0 of a frame. Without it the
//   position wraps on its own after frame_width x frame_height pixels.
//   For every interior pixel (one-pixel border excluded) one request leaves on
//   out_valid/out_ready: the AND of its 3x3 neighborhood, its row and column,
//   and frame_end on the last interior pixel of the frame.
//   Pipeline: the line store is read and the compute stage loaded when the
//   input is accepted; the output register is loaded when that stage advances.
//   Throughput: one pixel per cycle while out_ready stays high; the line store
//   is read at the accept edge and written back when the compute stage
//   advances, and a same-column read right behind a write is forwarded.
//   Stall: while out_ready is low the result waits in the output register;
//   border pixels still pass, and the next pixel with a result waits in the
//   compute stage with in_ready low.
//   Reset: counters, window registers and handshake state clear; registers
//   return to 640 x 480. The line store is not cleared; in normal operation
//   each column is written before its data is used in a result.
//   Configuration: cfg_write with cfg_index/cfg_data, only while idle.
module binary_erode_3x3_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [berode_pkg::CFG_W-1:0] cfg_data,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [berode_pkg::PIX_W-1:0] in_pixel,
	input  logic                        frame_start,
	// output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [berode_pkg::PIX_W-1:0] eroded_pixel,
	output logic [berode_pkg::ROW_W-1:0] center_row,
	output logic [$clog2(MAX_WIDTH-1)-1:0] center_col,
	output logic                        frame_end
);
	import berode_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int OCW = $clog2(MAX_WIDTH - 1);
	localparam int MW  = 2 * PIX_W;

	// configuration registers
	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;

	// position counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// line store: upper byte is the row two above, lower byte the row above
	logic [MW-1:0] line_mem [MAX_WIDTH];

	// compute stage
	logic                 valid_s1;
	stage_flags_t         flags_s1;
	logic [AW-1:0]        addr_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [OCW-1:0]       col_s1;
	logic [PIX_W-1:0]     pix_s1;
	logic [MW-1:0]        rd_s1;
	logic                 fwd_hit_s1;
	logic [MW-1:0]        fwd_s1;

	// window: previous two columns of upper, middle and current rows
	logic [PIX_W-1:0] win_q [6];

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] eroded_q;
	logic [ROW_W-1:0] row_q_out;
	logic [OCW-1:0]   col_q_out;
	logic             end_q;

	logic                accept;
	logic                s1_go;
	logic [CLAMP_W-1:0]  fw_ext;
	logic [CLAMP_W-1:0]  w_ext;
	logic [CW-1:0]       w;
	logic [ROW_W-1:0]    h;
	logic [CW-1:0]       c0;
	logic [ROW_W-1:0]    r0;
	logic [ROW_W-1:0]    r1;
	logic [CW-1:0]       c;
	logic [ROW_W-1:0]    r;
	stage_flags_t        flags_in;
	logic [MW-1:0]       line_eff;
	logic [PIX_W-1:0]    up_eff;
	logic [PIX_W-1:0]    mid_eff;
	logic [MW-1:0]       wr_data;
	logic [PIX_W-1:0]    and_val;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the registers to their usable ranges
	always_comb begin
		fw_ext = CLAMP_W'(frame_width_q);
		if (fw_ext < WIDTH_MIN)
			w_ext = WIDTH_MIN;
		else if (fw_ext > CLAMP_W'(MAX_WIDTH))
			w_ext = CLAMP_W'(MAX_WIDTH);
		else
			w_ext = fw_ext;
		w = w_ext[CW-1:0];
		if (frame_height_q < HEIGHT_MIN)
			h = HEIGHT_MIN;
		else
			h = frame_height_q;
	end

	// handshake
	assign s1_go    = valid_s1 && (!flags_s1.has_result || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	// position of the incoming pixel, with wrap and frame restart
	always_comb begin
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : row_q;
		if (c0 >= w) begin
			c  = '0;
			r1 = r0 + 1'b1;
		end else begin
			c  = c0;
			r1 = r0;
		end
		r = (r1 >= h) ? '0 : r1;
		flags_in.has_result = (r >= ROW_W'(2)) && (c >= CW'(2));
		flags_in.last       = (r == h - 1'b1) && (c == w - 1'b1);
	end

	// advance the position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= c + 1'b1;
			row_q <= r;
		end
	end

	// line store data seen by the compute stage, forwarded on a same-column hit
	always_comb begin
		line_eff = fwd_hit_s1 ? fwd_s1 : rd_s1;
		up_eff   = line_eff[MW-1:PIX_W];
		mid_eff  = line_eff[PIX_W-1:0];
		wr_data  = {mid_eff, pix_s1};
		and_val  = win_q[0] & win_q[1] & up_eff & win_q[2] & win_q[3] & mid_eff &
			win_q[4] & win_q[5] & pix_s1;
	end

	// line store: read at accept, write back when the compute stage advances
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= line_mem[c[AW-1:0]];
		if (s1_go)
			line_mem[addr_s1] <= wr_data;
	end

	// compute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// compute stage payload and forwarding capture
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1   <= flags_in;
			addr_s1    <= c[AW-1:0];
			row_s1     <= r - 1'b1;
			col_s1     <= OCW'(c - 1'b1);
			pix_s1     <= in_pixel;
			fwd_hit_s1 <= s1_go && (c[AW-1:0] == addr_s1);
			fwd_s1     <= wr_data;
		end
	end

	// shift the window when the compute stage advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (s1_go) begin
			win_q[0] <= win_q[1];
			win_q[1] <= up_eff;
			win_q[2] <= win_q[3];
			win_q[3] <= mid_eff;
			win_q[4] <= win_q[5];
			win_q[5] <= pix_s1;
		end
	end

	// output register valid: load on a result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && flags_s1.has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_go && flags_s1.has_result) begin
			eroded_q  <= and_val;
			row_q_out <= row_s1;
			col_q_out <= col_s1;
			end_q     <= flags_s1.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign eroded_pixel = eroded_q;
	assign center_row   = row_q_out;
	assign center_col   = col_q_out;
	assign frame_end    = end_q;

endmodule

/* verif/tb_binary_erode_3x3_core.sv */
`timescale 1ns / 100ps
// Testbench for binary_erode_3x3_core: streams directed and random frames
// under several frame sizes and checks every eroded pixel against its own window model.
// Depends on berode_pkg and the core RTL.

module tb_binary_erode_3x3_core;
	import berode_pkg::*;

	localparam int MAX_COLS       = 1024;
	localparam int COL_W          = 10;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int EXTREME_PIXELS = 30;
	localparam int RANDOM_PIXELS  = 360;
	localparam int QUIET_FROM     = 300;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} erosion_t;

	// Window model of the core plus the queue of erosions still owed by the core.
	class erosion_scoreboard;
		logic [FW_W-1:0]  width_reg;
		logic [ROW_W-1:0] height_reg;
		logic [PIX_W-1:0] upper_line [MAX_COLS];
		logic [PIX_W-1:0] middle_line [MAX_COLS];
		logic [PIX_W-1:0] window [6];
		int unsigned      col_pos;
		int unsigned      row_pos;
		erosion_t         expected_q [$];
		int               errors;
		int               checked;

		function new();
			width_reg  = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (window[i])
				window[i] = '0;
			col_pos = 0;
			row_pos = 0;
			errors  = 0;
			checked = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
			if (idx == REG_FRAME_WIDTH)
				width_reg = data[FW_W-1:0];
			else
				height_reg = data;
		endfunction

		function int unsigned used_width();
			if (width_reg < WIDTH_MIN)
				return WIDTH_MIN;
			if (width_reg > MAX_COLS)
				return MAX_COLS;
			return width_reg;
		endfunction

		// Advance the position and window by one accepted request; queue its erosion.
		function void note_pixel(logic [PIX_W-1:0] pix, logic start);
			int unsigned      w;
			int unsigned      h;
			logic [COL_W-1:0] idx;
			logic [PIX_W-1:0] up;
			logic [PIX_W-1:0] mid;
			erosion_t         res;
			w = used_width();
			h = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
			if (start) begin
				col_pos = 0;
				row_pos = 0;
			end
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos >= h)
				row_pos = 0;
			idx = col_pos[COL_W-1:0];
			up  = upper_line[idx];
			mid = middle_line[idx];
			// interior pixel (row_pos-1, col_pos-1) has its full neighborhood now
			if (row_pos >= 2 && col_pos >= 2) begin
				res.pixel = window[0] & window[1] & up & window[2] & window[3] & mid &
					window[4] & window[5] & pix;
				res.row  = ROW_W'(row_pos - 1);
				res.col  = COL_W'(col_pos - 1);
				res.last = (row_pos == h - 1) && (col_pos == w - 1);
				expected_q.push_back(res);
			end
			upper_line[idx]  = mid;
			middle_line[idx] = pix;
			window[0] = window[1];
			window[1] = up;
			window[2] = window[3];
			window[3] = mid;
			window[4] = window[5];
			window[5] = pix;
			col_pos++;
		endfunction

		// Compare one delivered result with the oldest owed erosion.
		function void check_result(logic [PIX_W-1:0] pix, logic [ROW_W-1:0] row,
				logic [COL_W-1:0] col, logic last);
			erosion_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: pixel %02h row %0d col %0d end %0b",
					$time, pix, row, col, last);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (pix !== want.pixel) begin
				errors++;
				$display("%0t: eroded_pixel at row %0d col %0d: expected %02h, actual %02h",
					$time, want.row, want.col, want.pixel, pix);
			end
			if (row !== want.row) begin
				errors++;
				$display("%0t: center_row: expected %0d, actual %0d", $time, want.row, row);
			end
			if (col !== want.col) begin
				errors++;
				$display("%0t: center_col: expected %0d, actual %0d", $time, want.col, col);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: frame_end at row %0d col %0d: expected %0b, actual %0b",
					$time, want.row, want.col, want.last, last);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic                 cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PIX_W-1:0]     in_pixel;
	logic                 frame_start;
	logic                 out_valid;
	logic                 out_ready;
	logic [PIX_W-1:0]     eroded_pixel;
	logic [ROW_W-1:0]     center_row;
	logic [COL_W-1:0]     center_col;
	logic                 frame_end;

	erosion_scoreboard sb = new();
	int  gap_odds       = 0;
	int  stall_odds     = 0;
	bit  start_pending  = 1'b0;
	int  pixels_in      = 0;
	int  settings_used  = 0;
	int  stalled_cycles = 0;

	binary_erode_3x3_core #(
		.MAX_WIDTH(MAX_COLS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_pixel(in_pixel),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.eroded_pixel(eroded_pixel),
		.center_row(center_row),
		.center_col(center_col),
		.frame_end(frame_end)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Track register writes and both channels at each edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_write)
				sb.write_reg(reg_index_t'(cfg_index), cfg_data);
			if (in_valid && in_ready) begin
				sb.note_pixel(in_pixel, frame_start);
				pixels_in++;
			end
			if (out_valid === 1'b1 && out_ready)
				sb.check_result(eroded_pixel, center_row, center_col, frame_end);
		end
	end

	// Abort when no request moves for too long.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: hold out_ready low in random bursts.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Offer one pixel, with an optional idle burst ahead of it; return once accepted.
	task automatic send_pixel(logic [PIX_W-1:0] pix, logic start);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		in_pixel    <= pix;
		frame_start <= start | start_pending;
		start_pending = 1'b0;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
	endtask

	// Send random pixels, biased so that the AND of nine is often nonzero.
	task automatic send_run(int n, int start_odds);
		logic [PIX_W-1:0] pix;
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: pix = 8'hFF;
				1: pix = PIX_W'($urandom);
				default: pix = PIX_W'($urandom | $urandom | $urandom);
			endcase
			send_pixel(pix, start_odds != 0 && $urandom_range(1, start_odds) == 1);
		end
	endtask

	// Stop sending and wait until every owed result has left the core.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers while idle; restart the frame if the width grew,
	// so that no line store column is used before it holds this frame's data.
	task automatic configure(logic [CFG_W-1:0] raw_width, logic [CFG_W-1:0] raw_height);
		int unsigned old_width;
		drain();
		old_width = sb.used_width();
		cfg_write <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= raw_width;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= raw_height;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (sb.used_width() > old_width)
			start_pending = 1'b1;
		settings_used++;
	endtask

	initial begin
		int random_pixels;
		int n;
		logic [CFG_W-1:0] raw_w;
		logic [CFG_W-1:0] raw_h;

		arst_n      <= 1'b0;
		cfg_write   <= 1'b0;
		cfg_index   <= REG_FRAME_WIDTH;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		in_pixel    <= '0;
		frame_start <= 1'b0;
		out_ready   <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero registers clamp to 3x3; full frame, wrap without
		// frame start, then a restart in the middle of a frame.
		configure(12'd0, 12'd0);
		for (int i = 0; i < 9; i++)
			send_pixel(8'hFF, i == 0);
		for (int i = 0; i < 9; i++)
			send_pixel((i == 8) ? 8'h7F : 8'hFF, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'h00, 1'b0);
		for (int i = 0; i < 9; i++)
			send_pixel((i == 4) ? 8'hA5 : 8'hFF, i == 0);

		// Extremes: widest row (raw value above range), then tallest frame.
		gap_odds   = 8;
		stall_odds = 8;
		configure(12'd2047, 12'd3);
		send_run(EXTREME_PIXELS, 0);
		configure(12'd1, 12'd4095);
		send_run(EXTREME_PIXELS, 0);

		// Random frame sizes, changed mid-frame too; no idling at the end.
		random_pixels = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			if (random_pixels >= QUIET_FROM) begin
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
				stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
			end
			if ($urandom_range(0, 9) == 0)
				raw_w = CFG_W'($urandom_range(0, 2));
			else
				raw_w = CFG_W'($urandom_range(3, 16));
			if ($urandom_range(0, 4) == 0)
				raw_w[FW_W] = 1'b1;
			if ($urandom_range(0, 9) == 0)
				raw_h = CFG_W'($urandom_range(0, 2));
			else
				raw_h = CFG_W'($urandom_range(3, 8));
			configure(raw_w, raw_h);
			if ($urandom_range(0, 3) == 0)
				start_pending = 1'b1;
			n = $urandom_range(1, 12 * sb.used_width());
			if (n > RANDOM_PIXELS - random_pixels)
				n = RANDOM_PIXELS - random_pixels;
			send_run(n, 60);
			random_pixels += n;
		end

		drain();
		$display("Covered %0d pixels and %0d eroded results over %0d frame settings,",
			pixels_in, sb.checked, settings_used);
		$display("with clamped registers, mid-frame restarts and wraps without frame start.");
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/berode_pkg.sv
rtl/core/binary_erode_3x3_core.sv
verif/tb_binary_erode_3x3_core.sv
